// ===== hdl/lpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpt_pkg
// Types and constants shared by the line protocol tokenizer.
// ----------------------------------------------------------------------------
package lpt_pkg;

   // Request beat: one character of the line
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // Response beat: label of the character and line status
   typedef struct packed {
      logic [2:0]  byte_class;
      logic        line_done;
      logic        line_ok;
      logic [63:0] time_value;
   } rsp_payload_type;

   // Parse section; the first five codes double as byte labels
   typedef enum logic [2:0] {
      SEC_MEAS     = 3'd0,
      SEC_TAGKEY   = 3'd1,
      SEC_TAGVAL   = 3'd2,
      SEC_FIELDKEY = 3'd3,
      SEC_FIELDVAL = 3'd4,
      SEC_TIME     = 3'd5
   } section_type;

   // Timestamp reader progress
   typedef enum logic [1:0] {
      PH_NONE   = 2'd0,
      PH_SPACE  = 2'd1,
      PH_SIGN   = 2'd2,
      PH_DIGITS = 2'd3
   } phase_type;

   // Labels that are not a section
   localparam logic [2:0] CLS_SEP  = 3'd5;
   localparam logic [2:0] CLS_TIME = 3'd6;
   localparam logic [2:0] CLS_ERR  = 3'd7;

   // Characters with a meaning
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   // Largest accumulator that can still take another digit
   localparam logic [63:0] ACC_LIMIT  = 64'd1844674407370955161;
   localparam logic [3:0]  LIMIT_DIG  = 4'd5;
   localparam logic [63:0] TIME_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ===== hdl/line_protocol_tokenizer.sv =====
// ----------------------------------------------------------------------------
// line_protocol_tokenizer
// Labels each character of a measurement/tags/fields/timestamp text line.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one character per beat with a last_byte flag on the
//   final character of a line. rsp channel returns one beat per request beat,
//   in order: the character's label, and on the last character line_done,
//   line_ok and the parsed timestamp (zero unless the line parsed fully).
//   Both channels move a beat on a clock edge with valid high and stall low.
// Pipeline and throughput:
//   A request beat is captured in an input register and labeled into the
//   response register when that register has room. One character per cycle is
//   sustained while rsp_stall stays low; the critical path is the timestamp
//   multiply-by-ten accumulate followed by the sign negate of the result.
// Reset:
//   Synchronous reset empties both registers and returns the parser to the
//   start of a line. After every last character the parser restarts as well.
// Backpressure:
//   While rsp_stall holds a full response register, the input register keeps
//   its beat and req_stall rises only when that input register is occupied.
// ----------------------------------------------------------------------------
module line_protocol_tokenizer
   import lpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // Pipeline registers
   logic            in_vld_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // Parser state
   section_type section_ff,  section_in;
   logic        quotes_ff,   quotes_in;
   logic        bs1_ff,      bs1_in;
   logic        bs2_ff,      bs2_in;
   logic [1:0]  pos_ff,      pos_in;
   logic [63:0] acc_ff,      acc_in;
   phase_type   phase_ff,    phase_in;
   logic        neg_ff,      neg_in;
   logic        ovf_ff,      ovf_in;
   logic        failed_ff,   failed_in;

   // Values after this beat, before the end-of-line restart
   section_type step_section;
   logic        step_quotes;
   logic [63:0] step_acc;
   phase_type   step_phase;
   logic        step_neg;
   logic        step_ovf;
   logic        step_failed;

   rsp_payload_type rsp_data_in;
   logic [2:0]      cls;

   logic        out_load;
   logic [7:0]  ch;
   logic        unesc;
   logic        is_digit;
   logic        is_space;
   logic [3:0]  digit;
   logic [63:0] acc_mul10;
   logic        acc_full;
   logic        line_ok;
   logic [63:0] time_out;

   // Advance the input register into the response register when room exists
   assign out_load  = in_vld_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_vld_ff && !out_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Character decode
   assign ch        = in_data_ff.data_byte;
   assign unesc     = (pos_ff != 2'd0) && (!bs1_ff || bs2_ff);
   assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_space  = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
   assign digit     = ch[3:0];
   assign acc_mul10 = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} + {60'd0, digit};
   assign acc_full  = (acc_ff > ACC_LIMIT) || ((acc_ff == ACC_LIMIT) && (digit > LIMIT_DIG));

   // Next state: one parse step
   always_comb begin
      logic q;
      q            = quotes_ff;
      step_section = section_ff;
      step_quotes  = quotes_ff;
      step_acc     = acc_ff;
      step_phase   = phase_ff;
      step_neg     = neg_ff;
      step_ovf     = ovf_ff;
      step_failed  = failed_ff;
      if (!failed_ff) begin
         case (section_ff)
            SEC_TIME: begin
               if (is_digit) begin
                  if (!ovf_ff) begin
                     if (acc_full) begin
                        step_ovf = 1'b1;
                     end else begin
                        step_acc = acc_mul10;
                     end
                  end
                  step_phase = PH_DIGITS;
               end else if ((phase_ff == PH_NONE || phase_ff == PH_SPACE) && is_space) begin
                  step_phase = PH_SPACE;
               end else if ((phase_ff == PH_NONE || phase_ff == PH_SPACE) &&
                            (ch == CH_PLUS || ch == CH_MINUS)) begin
                  step_neg   = (ch == CH_MINUS);
                  step_phase = PH_SIGN;
               end else begin
                  step_failed = 1'b1;
               end
            end
            SEC_TAGKEY, SEC_FIELDKEY: begin
               if (ch == CH_EQUAL && unesc) begin
                  step_section = (section_ff == SEC_TAGKEY) ? SEC_TAGVAL : SEC_FIELDVAL;
                  step_quotes  = 1'b0;
               end
            end
            default: begin
               if (section_ff != SEC_TAGVAL && section_ff != SEC_FIELDVAL) begin
                  step_section = SEC_MEAS;
               end
               if (ch == CH_QUOTE && unesc) begin
                  q = !q;
               end
               step_quotes = q;
               if (!q && (ch == CH_SPACE || ch == CH_COMMA) && unesc) begin
                  step_quotes = 1'b0;
                  if (section_ff == SEC_FIELDVAL) begin
                     step_section = (ch == CH_COMMA) ? SEC_FIELDKEY : SEC_TIME;
                  end else begin
                     step_section = (ch == CH_COMMA) ? SEC_TAGKEY : SEC_FIELDKEY;
                  end
               end
            end
         endcase
      end

      // Restart at line end
      if (in_data_ff.last_byte) begin
         section_in = SEC_MEAS;
         quotes_in  = 1'b0;
         bs1_in     = 1'b0;
         bs2_in     = 1'b0;
         pos_in     = 2'd0;
         acc_in     = 64'd0;
         phase_in   = PH_NONE;
         neg_in     = 1'b0;
         ovf_in     = 1'b0;
         failed_in  = 1'b0;
      end else begin
         section_in = step_section;
         quotes_in  = step_quotes;
         bs1_in     = (ch == CH_BACKSLASH);
         bs2_in     = bs1_ff;
         pos_in     = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
         acc_in     = step_acc;
         phase_in   = step_phase;
         neg_in     = step_neg;
         ovf_in     = step_ovf;
         failed_in  = step_failed;
      end
   end

   // Outputs: label and line status
   always_comb begin
      if (failed_ff) begin
         cls = CLS_ERR;
      end else if (section_ff == SEC_TIME) begin
         cls = step_failed ? CLS_ERR : CLS_TIME;
      end else if (step_section != section_ff || (section_ff != SEC_MEAS &&
                   section_ff != SEC_TAGKEY && section_ff != SEC_TAGVAL &&
                   section_ff != SEC_FIELDKEY && section_ff != SEC_FIELDVAL)) begin
         cls = (step_section == SEC_MEAS) ? 3'(SEC_MEAS) : CLS_SEP;
      end else begin
         cls = 3'(section_ff);
      end

      line_ok = in_data_ff.last_byte && !step_failed && (step_section == SEC_TIME) &&
                (step_phase == PH_NONE || step_phase == PH_DIGITS);
      if (step_ovf) begin
         time_out = TIME_MAX;
      end else if (step_neg) begin
         time_out = 64'd0 - step_acc;
      end else begin
         time_out = step_acc;
      end

      rsp_data_in.byte_class = cls;
      rsp_data_in.line_done  = in_data_ff.last_byte;
      rsp_data_in.line_ok    = line_ok;
      rsp_data_in.time_value = line_ok ? time_out : 64'd0;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= SEC_MEAS;
         quotes_ff  <= 1'b0;
         bs1_ff     <= 1'b0;
         bs2_ff     <= 1'b0;
         pos_ff     <= 2'd0;
         acc_ff     <= 64'd0;
         phase_ff   <= PH_NONE;
         neg_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         failed_ff  <= 1'b0;
      end else if (out_load) begin
         section_ff <= section_in;
         quotes_ff  <= quotes_in;
         bs1_ff     <= bs1_in;
         bs2_ff     <= bs2_in;
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         ovf_ff     <= ovf_in;
         failed_ff  <= failed_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A finished line leaves the parser at the start of a fresh line
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      out_load && in_data_ff.last_byte |=> section_ff == SEC_MEAS && !failed_ff)
      else $error("parser not restarted after line end");

   // Success is only reported on the last beat of a line
   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.line_ok |-> rsp_data_ff.line_done)
      else $error("line_ok without line_done");

   // A failed line labels every further beat as error
   a_sticky_fail: assert property (@(posedge clock) disable iff (reset)
      out_load && failed_ff |=> rsp_data_ff.byte_class == CLS_ERR)
      else $error("beat after failure not labeled as error");

   // Timestamp state stays clear outside the timestamp section
   a_time_idle: assert property (@(posedge clock) disable iff (reset)
      section_ff != SEC_TIME |-> acc_ff == 64'd0 && phase_ff == PH_NONE && !ovf_ff)
      else $error("timestamp state busy outside timestamp");
`endif

endmodule
